/* rtl/core/itoa_pkg.sv */
// Shared types, codes and character constants for the integer-to-ASCII formatter.
// No dependencies; used by itoa_digit_unit and integer_to_ascii_formatter.
package itoa_pkg;

	localparam int MAX_DIGITS      = 12;
	localparam int MAX_FIELD_WIDTH = 63;
	localparam int DIG_CNT_W       = $clog2(MAX_DIGITS + 1);
	localparam int DIG_IDX_W       = $clog2(MAX_DIGITS);

	// Base selection codes on the request.
	localparam logic [1:0] BASE_DEC  = 2'd0;
	localparam logic [1:0] BASE_OCT  = 2'd1;
	localparam logic [1:0] BASE_HEX  = 2'd2;
	localparam logic [1:0] BASE_NONE = 2'd3;

	// Flag bit positions.
	localparam int FLAG_UPPER = 0;
	localparam int FLAG_SPACE = 1;
	localparam int FLAG_PLUS  = 2;
	localparam int FLAG_ALT   = 3;
	localparam int FLAG_ZERO  = 4;
	localparam int FLAG_LEFT  = 5;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_X = 8'h58;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_X = 8'h78;

	// Ceiling of 2^35 / 10; the top bits of x * RECIP10 give x / 10 exactly for 32-bit x.
	localparam logic [31:0] RECIP10     = 32'hCCCCCCCD;
	localparam int          RECIP_SHIFT = 35;

	typedef enum logic [1:0] {
		RADIX_DEC,
		RADIX_OCT,
		RADIX_HEX
	} radix_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_PLAN,
		ST_EMIT
	} state_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {4'd0, d};
		end else if (upper) begin
			c = CH_UPPER_A + {4'd0, d - 4'd10};
		end else begin
			c = CH_LOWER_A + {4'd0, d - 4'd10};
		end
		return c;
	endfunction

endpackage

/* rtl/core/itoa_digit_unit.sv */
// Shared digit extractor: splits a 32-bit magnitude into quotient and low digit
// for radix 10, 8 or 16 combinationally. Depends on itoa_pkg.
module itoa_digit_unit (
	input  logic [31:0]          mag,
	input  itoa_pkg::radix_t     radix,
	output logic [31:0]          quo,
	output logic [3:0]           rem
);
	import itoa_pkg::*;

	logic [63:0] prod;
	logic [31:0] q10;
	logic [31:0] q10x;

	// Division by ten as a multiply by the scaled reciprocal.
	assign prod = 64'(mag) * 64'(RECIP10);
	assign q10  = 32'(prod >> RECIP_SHIFT);
	assign q10x = (q10 << 3) + (q10 << 1);

	always_comb begin
		unique case (radix)
			RADIX_DEC: begin
				quo = q10;
				rem = mag[3:0] - q10x[3:0];
			end
			RADIX_OCT: begin
				quo = mag >> 3;
				rem = {1'b0, mag[2:0]};
			end
			RADIX_HEX: begin
				quo = mag >> 4;
				rem = mag[3:0];
			end
			default: begin
				quo = '0;
				rem = '0;
			end
		endcase
	end

endmodule

/* rtl/core/integer_to_ascii_formatter.sv */
// Top level of the integer-to-ASCII formatter: sequencer, digit store and output register.
// Depends on itoa_pkg and itoa_digit_unit.
//
// Formats one 32-bit integer per request as signed decimal, octal or hex with printf-style
// flags and a minimum field width, and sends the field one character per output transfer,
// with last_char set on the final one. After a request is taken the block stalls its input
// until the last character has been loaded into the output register. The shared digit unit
// produces one digit per cycle (up to 10 for decimal, 11 for octal, 8 for hex), the plan state
// then lays out the padding and prefix, and the field follows at one character per cycle
// while the output is not stalled. A field of zero length (no-digit base code with zero width)
// produces no output.
module integer_to_ascii_formatter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [31:0] value,
	input  logic [1:0]  base_select,
	input  logic [5:0]  flag_bits,
	input  logic [5:0]  field_width,
	output logic        char_valid,
	input  logic        char_stall,
	output logic [7:0]  character,
	output logic        last_char
);
	import itoa_pkg::*;

	state_t state_q, state_d;

	logic [31:0]          mag_q;
	radix_t               radix_q;
	logic                 upper_q;
	logic                 left_q;
	logic                 zero_q;
	logic [5:0]           width_q;
	logic [1:0]           plen_q;
	logic [7:0]           pfx0_q, pfx1_q;
	logic [DIG_CNT_W-1:0] ndig_q;
	logic [3:0]           dig_q [MAX_DIGITS];

	logic [5:0] b1_q, b2_q, b3_q, b4_q, last_pos_q, pos_q;
	logic [7:0] ch_q;
	logic       last_q;
	logic       out_valid_q;

	logic [31:0] quo;
	logic [3:0]  rem;
	logic        accept;
	logic        conv_done;
	logic        emit_load;
	logic        emit_last;

	// Request decode
	logic        neg;
	logic [31:0] abs_val;
	logic [1:0]  plen_in;
	logic [7:0]  pfx0_in, pfx1_in;
	radix_t      radix_in;
	logic        upper_in;
	logic        left_in;
	logic        zero_in;
	logic [5:0]  width_in;

	// Layout
	logic [5:0] total;
	logic [5:0] pad;
	logic [5:0] pad_l, pad_z;
	logic [5:0] lay_b1, lay_b2, lay_b3, lay_b4, lay_len;

	// Emission
	logic [5:0] dig_off;
	logic [7:0] ch_sel;

	itoa_digit_unit u_digit (
		.mag   (mag_q),
		.radix (radix_q),
		.quo   (quo),
		.rem   (rem)
	);

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		neg      = 1'b0;
		abs_val  = value;
		plen_in  = 2'd0;
		pfx0_in  = CH_SPACE;
		pfx1_in  = CH_SPACE;
		radix_in = RADIX_DEC;
		upper_in = 1'b0;
		left_in  = flag_bits[FLAG_LEFT];
		zero_in  = !flag_bits[FLAG_LEFT] && flag_bits[FLAG_ZERO];
		width_in = (32'(field_width) > MAX_FIELD_WIDTH) ? 6'(MAX_FIELD_WIDTH) : field_width;
		unique case (base_select)
			BASE_DEC: begin
				neg     = value[31];
				abs_val = neg ? (32'd0 - value) : value;
				if (neg) begin
					plen_in = 2'd1;
					pfx0_in = CH_MINUS;
				end else if (flag_bits[FLAG_PLUS]) begin
					plen_in = 2'd1;
					pfx0_in = CH_PLUS;
				end else if (flag_bits[FLAG_SPACE]) begin
					plen_in = 2'd1;
					pfx0_in = CH_SPACE;
				end
			end
			BASE_OCT: begin
				radix_in = RADIX_OCT;
				if (value != 32'd0 && flag_bits[FLAG_ALT]) begin
					plen_in = 2'd1;
					pfx0_in = CH_ZERO;
				end
			end
			BASE_HEX: begin
				radix_in = RADIX_HEX;
				upper_in = flag_bits[FLAG_UPPER];
				if (value != 32'd0 && flag_bits[FLAG_ALT]) begin
					plen_in = 2'd2;
					pfx0_in = CH_ZERO;
					pfx1_in = flag_bits[FLAG_UPPER] ? CH_UPPER_X : CH_LOWER_X;
				end
			end
			default: begin
				plen_in = 2'd0;
			end
		endcase
	end

	assign conv_done = (quo == 32'd0) || (ndig_q == DIG_CNT_W'(MAX_DIGITS - 1));

	// Field layout: [left spaces][prefix][zeros][digits][right spaces].
	always_comb begin
		total   = 6'(plen_q) + 6'(ndig_q);
		pad     = (width_q > total) ? (width_q - total) : 6'd0;
		pad_l   = (!left_q && !zero_q) ? pad : 6'd0;
		pad_z   = zero_q ? pad : 6'd0;
		lay_b1  = pad_l;
		lay_b2  = lay_b1 + 6'(plen_q);
		lay_b3  = lay_b2 + pad_z;
		lay_b4  = lay_b3 + 6'(ndig_q);
		lay_len = (width_q > total) ? width_q : total;
	end

	always_comb begin
		dig_off = b4_q - 6'd1 - pos_q;
		if (pos_q < b1_q) begin
			ch_sel = CH_SPACE;
		end else if (pos_q < b2_q) begin
			ch_sel = (pos_q == b1_q) ? pfx0_q : pfx1_q;
		end else if (pos_q < b3_q) begin
			ch_sel = CH_ZERO;
		end else if (pos_q < b4_q) begin
			ch_sel = digit_char(dig_q[dig_off[DIG_IDX_W-1:0]], upper_q);
		end else begin
			ch_sel = CH_SPACE;
		end
	end

	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || !char_stall);
	assign emit_last = (pos_q == last_pos_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (base_select == BASE_NONE) ? ST_PLAN : ST_CONV;
				end
			end
			ST_CONV: begin
				if (conv_done) begin
					state_d = ST_PLAN;
				end
			end
			ST_PLAN: begin
				state_d = (lay_len == 6'd0) ? ST_IDLE : ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_load && emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ndig_q <= '0;
		end else if (accept) begin
			ndig_q <= '0;
		end else if (state_q == ST_CONV) begin
			ndig_q <= ndig_q + DIG_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q   <= abs_val;
			radix_q <= radix_in;
			upper_q <= upper_in;
			left_q  <= left_in;
			zero_q  <= zero_in;
			width_q <= width_in;
			plen_q  <= plen_in;
			pfx0_q  <= pfx0_in;
			pfx1_q  <= pfx1_in;
		end else if (state_q == ST_CONV) begin
			mag_q                                 <= quo;
			dig_q[ndig_q[DIG_IDX_W-1:0]]          <= rem;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PLAN) begin
			b1_q       <= lay_b1;
			b2_q       <= lay_b2;
			b3_q       <= lay_b3;
			b4_q       <= lay_b4;
			last_pos_q <= lay_len - 6'd1;
			pos_q      <= 6'd0;
		end else if (emit_load) begin
			pos_q <= pos_q + 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!char_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			ch_q   <= ch_sel;
			last_q <= emit_last;
		end
	end

	assign char_valid = out_valid_q;
	assign character  = ch_q;
	assign last_char  = last_q;

	a_ndig_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ndig_q <= DIG_CNT_W'(MAX_DIGITS))
		else $error("digit count beyond the digit store");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> pos_q <= last_pos_q)
		else $error("emit position ran past the end of the field");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load && emit_last |=> state_q == ST_IDLE && char_valid && last_char)
		else $error("final character did not close the request");

	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(char_valid) |-> $past(state_q == ST_EMIT))
		else $error("output loaded outside of emission");

	a_digits_fit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> b4_q <= last_pos_q + 6'd1)
		else $error("digits laid out beyond the field length");

endmodule
